FILE: rtl/rai_pkg.sv
package rai_pkg;

    localparam int T_STAGES  = 48;
    localparam int UV_STAGES = 17;

    localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        AXIS_Z = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_X = 2'd2
    } t_axis;

    typedef enum logic [2:0] {
        CFG_AXIS        = 3'd0,
        CFG_OFFSET      = 3'd1,
        CFG_FIRST_LOW   = 3'd2,
        CFG_FIRST_HIGH  = 3'd3,
        CFG_SECOND_LOW  = 3'd4,
        CFG_SECOND_HIGH = 3'd5,
        CFG_MATERIAL    = 3'd6
    } t_cfg_idx;

    // Ray data carried alongside the distance divider.
    typedef struct packed {
        logic signed [31:0] org_x;
        logic signed [31:0] org_y;
        logic signed [31:0] org_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] t_min;
        logic signed [31:0] t_max;
        logic               q_neg;
        logic               live;
        logic               front;
    } t_tside;

    // Hit data carried alongside the u and v dividers.
    typedef struct packed {
        logic               hit;
        logic signed [31:0] t_val;
        logic               front;
        logic signed [31:0] pt_x;
        logic signed [31:0] pt_y;
        logic signed [31:0] pt_z;
        logic               u_zero;
        logic               v_zero;
    } t_uvside;

    // One restoring division step: returns {quotient bit, new remainder}.
    // The remainder stays below the divisor, so it always fits 32 bits.
    function automatic logic [32:0] div_step(input logic [31:0] rem, input logic in_bit,
                                             input logic [31:0] den);
        logic [33:0] trial;
        trial = {1'b0, rem, in_bit} - {2'b00, den};
        if (!trial[33]) begin
            div_step = {1'b1, trial[31:0]};
        end else begin
            div_step = {1'b0, rem[30:0], in_bit};
        end
    endfunction

endpackage

FILE: rtl/ray_axis_rect_intersect.sv
// Ray against axis-aligned rectangle test, one ray per cycle unless the receiver stalls.
// Input channel: i_in_valid / o_in_ready with the ray origin, direction and
// accepted distance range. Output channel: o_out_valid / i_out_ready with one
// result per ray; on a miss every result field is zero.
// The rectangle, its plane and its material are set through the write port
// (i_cfg_we, i_cfg_addr, i_cfg_data). The user must write them only while no
// ray is in flight; the block does not enforce it. A ray passes through 71
// registers from the input transfer to the result, the first of them loaded
// by the transfer itself: one setup stage, 48 restoring steps for the hit
// distance, four stages for range test, multiply, hit point and bound test,
// 17 steps for u and v, and the output register.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so a stalled receiver holds every stage in place and the
// input is refused only while the output is full and not taken.
// A synchronous reset empties the pipeline and loads the register defaults:
// plane z, offset 0, unit square from 0.0 to 1.0 on both axes, material 0.
module ray_axis_rect_intersect (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_addr,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [31:0]   i_origin_x,
    input  logic signed [31:0]   i_origin_y,
    input  logic signed [31:0]   i_origin_z,
    input  logic signed [31:0]   i_dir_x,
    input  logic signed [31:0]   i_dir_y,
    input  logic signed [31:0]   i_dir_z,
    input  logic signed [31:0]   i_t_min,
    input  logic signed [31:0]   i_t_max,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_hit,
    output logic signed [31:0]   o_hit_t,
    output logic [16:0]          o_coord_u,
    output logic [16:0]          o_coord_v,
    output logic                 o_front_face,
    output logic signed [31:0]   o_point_x,
    output logic signed [31:0]   o_point_y,
    output logic signed [31:0]   o_point_z,
    output logic [15:0]          o_hit_material
);

    // Configuration registers.
    logic [1:0]          r_axis;
    logic signed [31:0]  r_offset, r_flo, r_fhi, r_slo, r_shi;
    logic [15:0]         r_material;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis     <= rai_pkg::AXIS_Z;
            r_offset   <= 32'sd0;
            r_flo      <= 32'sd0;
            r_fhi      <= 32'sd65536;
            r_slo      <= 32'sd0;
            r_shi      <= 32'sd65536;
            r_material <= 16'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rai_pkg::CFG_AXIS:        r_axis     <= i_cfg_data[1:0];
                rai_pkg::CFG_OFFSET:      r_offset   <= i_cfg_data;
                rai_pkg::CFG_FIRST_LOW:   r_flo      <= i_cfg_data;
                rai_pkg::CFG_FIRST_HIGH:  r_fhi      <= i_cfg_data;
                rai_pkg::CFG_SECOND_LOW:  r_slo      <= i_cfg_data;
                rai_pkg::CFG_SECOND_HIGH: r_shi      <= i_cfg_data;
                rai_pkg::CFG_MATERIAL:    r_material <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic r_o_valid;
    assign en         = !r_o_valid || i_out_ready;
    assign o_in_ready = en;

    // Setup stage: pick the plane axis and form the offset difference.
    logic signed [31:0]  org_a, dir_a;
    logic                axis_ok;
    logic signed [32:0]  n_p_num;
    rai_pkg::t_tside     n_p_side;

    always_comb begin
        case (r_axis)
            rai_pkg::AXIS_Z: begin
                org_a = i_origin_z; dir_a = i_dir_z; axis_ok = 1'b1;
            end
            rai_pkg::AXIS_Y: begin
                org_a = i_origin_y; dir_a = i_dir_y; axis_ok = 1'b1;
            end
            rai_pkg::AXIS_X: begin
                org_a = i_origin_x; dir_a = i_dir_x; axis_ok = 1'b1;
            end
            default: begin
                org_a = i_origin_x; dir_a = i_dir_x; axis_ok = 1'b0;
            end
        endcase
        n_p_num         = 33'(r_offset) - 33'(org_a);
        n_p_side.org_x  = i_origin_x;
        n_p_side.org_y  = i_origin_y;
        n_p_side.org_z  = i_origin_z;
        n_p_side.dir_x  = i_dir_x;
        n_p_side.dir_y  = i_dir_y;
        n_p_side.dir_z  = i_dir_z;
        n_p_side.t_min  = i_t_min;
        n_p_side.t_max  = i_t_max;
        n_p_side.q_neg  = n_p_num[32] ^ dir_a[31];
        n_p_side.live   = axis_ok && (dir_a != 32'sd0);
        n_p_side.front  = dir_a[31];
    end

    logic                r_p_valid;
    logic signed [32:0]  r_p_num;
    logic signed [31:0]  r_p_den;
    rai_pkg::t_tside     r_p_side;

    logic                td_valid;
    logic [47:0]         td_quo;
    rai_pkg::t_tside     td_side;

    rai_t_div u_t_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_p_valid),
        .i_num   (r_p_num),
        .i_den   (r_p_den),
        .i_side  (r_p_side),
        .o_valid (td_valid),
        .o_quo   (td_quo),
        .o_side  (td_side)
    );

    // Range test on the full-width distance.
    logic signed [48:0]  t_full;
    logic                t_in;

    always_comb begin
        t_full = td_side.q_neg ? -$signed({1'b0, td_quo}) : $signed({1'b0, td_quo});
        t_in   = td_side.live && (t_full >= 49'(td_side.t_min))
                              && (t_full <= 49'(td_side.t_max));
    end

    logic                r_t_valid, r_t_hit;
    logic signed [31:0]  r_t_val;
    rai_pkg::t_tside     r_t_side;

    logic                r_m_valid, r_m_hit, r_m_front;
    logic signed [31:0]  r_m_t, r_m_org_x, r_m_org_y, r_m_org_z;
    logic signed [63:0]  r_m_prod_x, r_m_prod_y, r_m_prod_z;

    logic                r_a_valid, r_a_hit, r_a_front;
    logic signed [31:0]  r_a_t;
    logic signed [48:0]  r_a_pt_x, r_a_pt_y, r_a_pt_z;

    // Bound test and normalisation operands.
    logic signed [48:0]  pt_f, pt_s;
    logic                in_bounds;
    logic signed [49:0]  diff_f, diff_s;
    logic signed [32:0]  w_f, w_s;
    rai_pkg::t_uvside    n_b_side;

    function automatic logic signed [31:0] sat32(input logic signed [48:0] x);
        if (x > 49'(rai_pkg::SAT_MAX)) begin
            sat32 = rai_pkg::SAT_MAX;
        end else if (x < 49'(rai_pkg::SAT_MIN)) begin
            sat32 = rai_pkg::SAT_MIN;
        end else begin
            sat32 = x[31:0];
        end
    endfunction

    always_comb begin
        if (r_axis == rai_pkg::AXIS_X) begin
            pt_f = r_a_pt_y;
        end else begin
            pt_f = r_a_pt_x;
        end
        if (r_axis == rai_pkg::AXIS_Z) begin
            pt_s = r_a_pt_y;
        end else begin
            pt_s = r_a_pt_z;
        end
        in_bounds = (pt_f >= 49'(r_flo)) && (pt_f <= 49'(r_fhi))
                 && (pt_s >= 49'(r_slo)) && (pt_s <= 49'(r_shi));
        diff_f = 50'(pt_f) - 50'(r_flo);
        diff_s = 50'(pt_s) - 50'(r_slo);
        w_f    = 33'(r_fhi) - 33'(r_flo);
        w_s    = 33'(r_shi) - 33'(r_slo);
        n_b_side.hit    = r_a_hit && in_bounds;
        n_b_side.t_val  = r_a_t;
        n_b_side.front  = r_a_front;
        n_b_side.pt_x   = sat32(r_a_pt_x);
        n_b_side.pt_y   = sat32(r_a_pt_y);
        n_b_side.pt_z   = sat32(r_a_pt_z);
        n_b_side.u_zero = (r_fhi == r_flo);
        n_b_side.v_zero = (r_shi == r_slo);
    end

    logic                r_b_valid;
    logic [31:0]         r_b_diff_u, r_b_w_u, r_b_diff_v, r_b_w_v;
    rai_pkg::t_uvside    r_b_side;

    logic                uv_valid;
    logic [16:0]         uv_u, uv_v;
    rai_pkg::t_uvside    uv_side;

    rai_uv_div u_uv_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r_b_valid),
        .i_diff_u (r_b_diff_u),
        .i_w_u    (r_b_w_u),
        .i_diff_v (r_b_diff_v),
        .i_w_v    (r_b_w_v),
        .i_side   (r_b_side),
        .o_valid  (uv_valid),
        .o_u      (uv_u),
        .o_v      (uv_v),
        .o_side   (uv_side)
    );

    logic                r_o_hit, r_o_front;
    logic signed [31:0]  r_o_t, r_o_px, r_o_py, r_o_pz;
    logic [16:0]         r_o_u, r_o_v;
    logic [15:0]         r_o_mat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_t_valid <= 1'b0;
            r_m_valid <= 1'b0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_p_valid <= i_in_valid;
            r_t_valid <= td_valid;
            r_m_valid <= r_t_valid;
            r_a_valid <= r_m_valid;
            r_b_valid <= r_a_valid;
            r_o_valid <= uv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_num    <= n_p_num;
            r_p_den    <= dir_a;
            r_p_side   <= n_p_side;

            r_t_hit    <= t_in;
            r_t_val    <= t_full[31:0];
            r_t_side   <= td_side;

            r_m_hit    <= r_t_hit;
            r_m_front  <= r_t_side.front;
            r_m_t      <= r_t_val;
            r_m_org_x  <= r_t_side.org_x;
            r_m_org_y  <= r_t_side.org_y;
            r_m_org_z  <= r_t_side.org_z;
            r_m_prod_x <= 64'(r_t_val) * 64'(r_t_side.dir_x);
            r_m_prod_y <= 64'(r_t_val) * 64'(r_t_side.dir_y);
            r_m_prod_z <= 64'(r_t_val) * 64'(r_t_side.dir_z);

            // An arithmetic shift by 16 floors the Q32.32 product to Q32.16.
            r_a_hit    <= r_m_hit;
            r_a_front  <= r_m_front;
            r_a_t      <= r_m_t;
            r_a_pt_x   <= 49'(r_m_org_x) + 49'($signed(r_m_prod_x[63:16]));
            r_a_pt_y   <= 49'(r_m_org_y) + 49'($signed(r_m_prod_y[63:16]));
            r_a_pt_z   <= 49'(r_m_org_z) + 49'($signed(r_m_prod_z[63:16]));

            r_b_diff_u <= diff_f[31:0];
            r_b_w_u    <= w_f[31:0];
            r_b_diff_v <= diff_s[31:0];
            r_b_w_v    <= w_s[31:0];
            r_b_side   <= n_b_side;

            r_o_hit    <= uv_side.hit;
            r_o_t      <= uv_side.hit ? uv_side.t_val : 32'sd0;
            r_o_u      <= (uv_side.hit && !uv_side.u_zero) ? uv_u : 17'd0;
            r_o_v      <= (uv_side.hit && !uv_side.v_zero) ? uv_v : 17'd0;
            r_o_front  <= uv_side.hit && uv_side.front;
            r_o_px     <= uv_side.hit ? uv_side.pt_x : 32'sd0;
            r_o_py     <= uv_side.hit ? uv_side.pt_y : 32'sd0;
            r_o_pz     <= uv_side.hit ? uv_side.pt_z : 32'sd0;
            r_o_mat    <= uv_side.hit ? r_material : 16'd0;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_hit          = r_o_hit;
    assign o_hit_t        = r_o_t;
    assign o_coord_u      = r_o_u;
    assign o_coord_v      = r_o_v;
    assign o_front_face   = r_o_front;
    assign o_point_x      = r_o_px;
    assign o_point_y      = r_o_py;
    assign o_point_z      = r_o_pz;
    assign o_hit_material = r_o_mat;

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !r_o_valid)
        else $error("output valid right after reset");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_hit) |-> (r_o_t == 32'sd0 && r_o_u == 17'd0 && r_o_v == 17'd0
            && !r_o_front && r_o_px == 32'sd0 && r_o_py == 32'sd0 && r_o_pz == 32'sd0
            && r_o_mat == 16'd0))
        else $error("miss result carries non-zero fields");

    a_coord_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_hit) |-> (r_o_u <= 17'd65536 && r_o_v <= 17'd65536))
        else $error("normalised coordinate above one");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en) |=> ($stable(r_b_valid) && $stable(r_t_valid) && $stable(r_p_valid)))
        else $error("pipeline moved during a stall");

endmodule

FILE: rtl/rai_t_div.sv
module rai_t_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [32:0]   i_num,
    input  logic signed [31:0]   i_den,
    input  rai_pkg::t_tside      i_side,
    output logic                 o_valid,
    output logic [47:0]          o_quo,
    output rai_pkg::t_tside      o_side
);

    logic                 r_valid [rai_pkg::T_STAGES];
    logic [31:0]          r_rem   [rai_pkg::T_STAGES];
    logic [47:0]          r_acc   [rai_pkg::T_STAGES];
    logic [31:0]          r_den   [rai_pkg::T_STAGES];
    rai_pkg::t_tside      r_side  [rai_pkg::T_STAGES];

    logic [31:0]          n_rem   [rai_pkg::T_STAGES];
    logic [47:0]          n_acc   [rai_pkg::T_STAGES];
    logic [31:0]          n_den   [rai_pkg::T_STAGES];

    always_comb begin
        logic [32:0] num_mag;
        logic [31:0] rem;
        logic [47:0] acc;
        logic [31:0] den;
        logic [32:0] step;
        num_mag = i_num[32] ? 33'(-i_num) : 33'(i_num);
        for (int k = 0; k < rai_pkg::T_STAGES; k++) begin
            if (k == 0) begin
                // The dividend is the magnitude of the offset difference scaled by 2^16.
                rem = 32'd0;
                acc = {num_mag[31:0], 16'd0};
                den = i_den[31] ? 32'(-i_den) : 32'(i_den);
            end else begin
                rem = r_rem[k-1];
                acc = r_acc[k-1];
                den = r_den[k-1];
            end
            step     = rai_pkg::div_step(rem, acc[47], den);
            n_rem[k] = step[31:0];
            n_acc[k] = {acc[46:0], step[32]};
            n_den[k] = den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rai_pkg::T_STAGES; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (i_en) begin
            for (int k = 0; k < rai_pkg::T_STAGES; k++) begin
                r_valid[k] <= (k == 0) ? i_valid : r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < rai_pkg::T_STAGES; k++) begin
                r_rem[k]  <= n_rem[k];
                r_acc[k]  <= n_acc[k];
                r_den[k]  <= n_den[k];
                r_side[k] <= (k == 0) ? i_side : r_side[k-1];
            end
        end
    end

    assign o_valid = r_valid[rai_pkg::T_STAGES-1];
    assign o_quo   = r_acc[rai_pkg::T_STAGES-1];
    assign o_side  = r_side[rai_pkg::T_STAGES-1];

endmodule

FILE: rtl/rai_uv_div.sv
module rai_uv_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [31:0]          i_diff_u,
    input  logic [31:0]          i_w_u,
    input  logic [31:0]          i_diff_v,
    input  logic [31:0]          i_w_v,
    input  rai_pkg::t_uvside     i_side,
    output logic                 o_valid,
    output logic [16:0]          o_u,
    output logic [16:0]          o_v,
    output rai_pkg::t_uvside     o_side
);

    logic                 r_valid [rai_pkg::UV_STAGES];
    logic [31:0]          r_rem_u [rai_pkg::UV_STAGES];
    logic [16:0]          r_acc_u [rai_pkg::UV_STAGES];
    logic [31:0]          r_den_u [rai_pkg::UV_STAGES];
    logic [31:0]          r_rem_v [rai_pkg::UV_STAGES];
    logic [16:0]          r_acc_v [rai_pkg::UV_STAGES];
    logic [31:0]          r_den_v [rai_pkg::UV_STAGES];
    rai_pkg::t_uvside     r_side  [rai_pkg::UV_STAGES];

    logic [31:0]          n_rem_u [rai_pkg::UV_STAGES];
    logic [16:0]          n_acc_u [rai_pkg::UV_STAGES];
    logic [31:0]          n_den_u [rai_pkg::UV_STAGES];
    logic [31:0]          n_rem_v [rai_pkg::UV_STAGES];
    logic [16:0]          n_acc_v [rai_pkg::UV_STAGES];
    logic [31:0]          n_den_v [rai_pkg::UV_STAGES];

    always_comb begin
        logic [31:0] rem_u, rem_v, den_u, den_v;
        logic [16:0] acc_u, acc_v;
        logic [32:0] step_u, step_v;
        for (int k = 0; k < rai_pkg::UV_STAGES; k++) begin
            if (k == 0) begin
                // The quotient is at most 2^16, so the top bits of the scaled
                // difference start out in the remainder.
                rem_u = {1'b0, i_diff_u[31:1]};
                acc_u = {i_diff_u[0], 16'd0};
                den_u = i_w_u;
                rem_v = {1'b0, i_diff_v[31:1]};
                acc_v = {i_diff_v[0], 16'd0};
                den_v = i_w_v;
            end else begin
                rem_u = r_rem_u[k-1];
                acc_u = r_acc_u[k-1];
                den_u = r_den_u[k-1];
                rem_v = r_rem_v[k-1];
                acc_v = r_acc_v[k-1];
                den_v = r_den_v[k-1];
            end
            step_u     = rai_pkg::div_step(rem_u, acc_u[16], den_u);
            step_v     = rai_pkg::div_step(rem_v, acc_v[16], den_v);
            n_rem_u[k] = step_u[31:0];
            n_acc_u[k] = {acc_u[15:0], step_u[32]};
            n_den_u[k] = den_u;
            n_rem_v[k] = step_v[31:0];
            n_acc_v[k] = {acc_v[15:0], step_v[32]};
            n_den_v[k] = den_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rai_pkg::UV_STAGES; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (i_en) begin
            for (int k = 0; k < rai_pkg::UV_STAGES; k++) begin
                r_valid[k] <= (k == 0) ? i_valid : r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < rai_pkg::UV_STAGES; k++) begin
                r_rem_u[k] <= n_rem_u[k];
                r_acc_u[k] <= n_acc_u[k];
                r_den_u[k] <= n_den_u[k];
                r_rem_v[k] <= n_rem_v[k];
                r_acc_v[k] <= n_acc_v[k];
                r_den_v[k] <= n_den_v[k];
                r_side[k]  <= (k == 0) ? i_side : r_side[k-1];
            end
        end
    end

    assign o_valid = r_valid[rai_pkg::UV_STAGES-1];
    assign o_u     = r_acc_u[rai_pkg::UV_STAGES-1];
    assign o_v     = r_acc_v[rai_pkg::UV_STAGES-1];
    assign o_side  = r_side[rai_pkg::UV_STAGES-1];

endmodule

FILE: verif/tb_ray_axis_rect_intersect.sv
`timescale 1ns / 1ps

module tb_ray_axis_rect_intersect;

    localparam longint ONE = 65536;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic signed [31:0] ox, oy, oz, dx, dy, dz, tmin, tmax;
    } t_ray;

    typedef struct packed {
        logic        hit;
        logic [31:0] t;
        logic [16:0] u, v;
        logic        front;
        logic [31:0] px, py, pz;
        logic [15:0] mat;
    } t_hit_rec;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_addr = '0;
    logic [31:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic o_hit, o_front_face;
    logic signed [31:0] o_hit_t, o_point_x, o_point_y, o_point_z;
    logic [16:0] o_coord_u, o_coord_v;
    logic [15:0] o_hit_material;
    t_ray drv_ray = '0;

    // Copy of the rectangle registers as the block should hold them.
    logic [1:0] sh_axis = rai_pkg::AXIS_Z;
    logic signed [31:0] sh_offset = 0, sh_flo = 0, sh_fhi = 32'sd65536;
    logic signed [31:0] sh_slo = 0, sh_shi = 32'sd65536;
    logic [15:0] sh_mat = 0;

    t_ray pending_rays[$];
    t_hit_rec expected_hits[$];
    int in_idle_pct = 26, out_idle_pct = 71;
    int hold_cnt = 0;
    int fail_cnt = 0;
    int cycles = 0;

    ray_axis_rect_intersect u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_origin_x(drv_ray.ox), .i_origin_y(drv_ray.oy), .i_origin_z(drv_ray.oz),
        .i_dir_x(drv_ray.dx), .i_dir_y(drv_ray.dy), .i_dir_z(drv_ray.dz),
        .i_t_min(drv_ray.tmin), .i_t_max(drv_ray.tmax),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_hit(o_hit), .o_hit_t(o_hit_t), .o_coord_u(o_coord_u), .o_coord_v(o_coord_v),
        .o_front_face(o_front_face), .o_point_x(o_point_x), .o_point_y(o_point_y),
        .o_point_z(o_point_z), .o_hit_material(o_hit_material)
    );

    always #4 i_clk = ~i_clk;

    function automatic longint norm_pos(longint p, longint lo, longint hi);
        if (hi - lo <= 0) begin
            return 0;
        end
        return ((p - lo) * ONE) / (hi - lo);
    endfunction

    function automatic longint sat32(longint x);
        if (x > 64'sh7fff_ffff) begin
            return 64'sh7fff_ffff;
        end
        if (x < -64'sh8000_0000) begin
            return -64'sh8000_0000;
        end
        return x;
    endfunction

    function automatic t_hit_rec intersect_ray(t_ray r);
        t_hit_rec res;
        longint o[3], d[3], p[3];
        longint t, flo, fhi, slo, shi;
        int a, f, s;
        res = '0;
        o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
        d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
        flo = sh_flo; fhi = sh_fhi; slo = sh_slo; shi = sh_shi;
        case (sh_axis)
            rai_pkg::AXIS_Z: begin a = 2; f = 0; s = 1; end
            rai_pkg::AXIS_Y: begin a = 1; f = 0; s = 2; end
            rai_pkg::AXIS_X: begin a = 0; f = 1; s = 2; end
            default: return res;
        endcase
        if (d[a] == 0) begin
            return res;
        end
        t = ((longint'(sh_offset) - o[a]) * ONE) / d[a];
        if (t < longint'(r.tmin) || t > longint'(r.tmax)) begin
            return res;
        end
        // An arithmetic shift of the product gives the floor of the Q16.16 step.
        for (int i = 0; i < 3; i++) begin
            p[i] = o[i] + ((t * d[i]) >>> 16);
        end
        if (p[f] < flo || p[f] > fhi || p[s] < slo || p[s] > shi) begin
            return res;
        end
        res.hit = 1'b1;
        res.t = t[31:0];
        res.u = 17'(norm_pos(p[f], flo, fhi));
        res.v = 17'(norm_pos(p[s], slo, shi));
        res.front = d[a] < 0;
        res.px = 32'(sat32(p[0]));
        res.py = 32'(sat32(p[1]));
        res.pz = 32'(sat32(p[2]));
        res.mat = sh_mat;
        return res;
    endfunction

    // Driver: a new ray is offered only once the previous one has been transferred.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_hits.push_back(intersect_ray(drv_ray));
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_rays.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
                    drv_ray <= pending_rays.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    // Monitor and receiver.
    always @(posedge i_clk) begin
        t_hit_rec e;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_hits.size() == 0) begin
                    $error("result transfer with no ray outstanding");
                    fail_cnt++;
                end else begin
                    e = expected_hits.pop_front();
                    check_field("hit", e.hit, o_hit);
                    check_field("hit_t", e.t, o_hit_t);
                    check_field("coord_u", e.u, o_coord_u);
                    check_field("coord_v", e.v, o_coord_v);
                    check_field("front_face", e.front, o_front_face);
                    check_field("point_x", e.px, o_point_x);
                    check_field("point_y", e.py, o_point_y);
                    check_field("point_z", e.pz, o_point_z);
                    check_field("hit_material", e.mat, o_hit_material);
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= $urandom_range(99) >= out_idle_pct;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic cfg_write(rai_pkg::t_cfg_idx idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_rect(logic [1:0] axis, logic [31:0] off, logic [31:0] flo,
                            logic [31:0] fhi, logic [31:0] slo, logic [31:0] shi,
                            logic [15:0] mat);
        cfg_write(rai_pkg::CFG_AXIS, {30'd0, axis});
        cfg_write(rai_pkg::CFG_OFFSET, off);
        cfg_write(rai_pkg::CFG_FIRST_LOW, flo);
        cfg_write(rai_pkg::CFG_FIRST_HIGH, fhi);
        cfg_write(rai_pkg::CFG_SECOND_LOW, slo);
        cfg_write(rai_pkg::CFG_SECOND_HIGH, shi);
        cfg_write(rai_pkg::CFG_MATERIAL, {16'd0, mat});
        sh_axis = axis; sh_offset = off; sh_flo = flo; sh_fhi = fhi;
        sh_slo = slo; sh_shi = shi; sh_mat = mat;
    endtask

    task automatic wait_drained();
        while (pending_rays.size() != 0 || i_in_valid || expected_hits.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (80) @(posedge i_clk);
    endtask

    task automatic add_ray(longint ox, longint oy, longint oz, longint dx, longint dy,
                           longint dz, longint tmin, longint tmax);
        t_ray r;
        r.ox = ox[31:0]; r.oy = oy[31:0]; r.oz = oz[31:0];
        r.dx = dx[31:0]; r.dy = dy[31:0]; r.dz = dz[31:0];
        r.tmin = tmin[31:0]; r.tmax = tmax[31:0];
        pending_rays.push_back(r);
    endtask

    function automatic longint pick_between(longint lo, longint hi);
        if (hi <= lo) begin
            return lo;
        end
        return lo + ((hi - lo) * longint'($urandom_range(0, 65536))) / ONE;
    endfunction

    // Mostly rays aimed at a point on the rectangle, the rest random noise.
    task automatic add_random_rays(int n);
        longint d[3], p[3], o[3], t;
        int a, f, s;
        t_ray r;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 15) begin
                r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom};
                pending_rays.push_back(r);
            end else begin
                case (sh_axis)
                    rai_pkg::AXIS_Y: begin a = 1; f = 0; s = 2; end
                    rai_pkg::AXIS_X: begin a = 0; f = 1; s = 2; end
                    default: begin a = 2; f = 0; s = 1; end
                endcase
                for (int i = 0; i < 3; i++) begin
                    if ($urandom_range(7) == 0) begin
                        d[i] = longint'($signed($urandom));
                    end else begin
                        d[i] = longint'($urandom_range(0, 8 * ONE)) - 4 * ONE;
                    end
                end
                t = $urandom_range(0, 16 * ONE);
                p[a] = sh_offset;
                p[f] = pick_between(sh_flo, sh_fhi);
                p[s] = pick_between(sh_slo, sh_shi);
                for (int i = 0; i < 3; i++) begin
                    o[i] = p[i] - ((t * d[i]) >>> 16);
                end
                case ($urandom_range(3))
                    0: add_ray(o[0], o[1], o[2], d[0], d[1], d[2], 0, 64'sh7fff_ffff);
                    1: add_ray(o[0], o[1], o[2], d[0], d[1], d[2],
                               t - $urandom_range(0, 4), t + $urandom_range(0, 4));
                    2: add_ray(o[0], o[1], o[2], d[0], d[1], d[2],
                               longint'($signed($urandom)), longint'($signed($urandom)));
                    default: add_ray(o[0], o[1], o[2], d[0], d[1], d[2],
                               -64'sh8000_0000, t - 1 + $urandom_range(0, 2));
                endcase
            end
        end
        wait_drained();
    endtask

    task automatic random_rect(logic [1:0] axis, int n);
        longint lo1, lo2;
        lo1 = longint'($urandom_range(0, 16 * ONE)) - 8 * ONE;
        lo2 = longint'($urandom_range(0, 16 * ONE)) - 8 * ONE;
        set_rect(axis, 32'(longint'($urandom_range(0, 16 * ONE)) - 8 * ONE), lo1[31:0],
                 32'(lo1 + $urandom_range(1, 16 * ONE)), lo2[31:0],
                 32'(lo2 + $urandom_range(1, 16 * ONE)), 16'($urandom));
        add_random_rays(n);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rays against the reset unit square in the plane z = 0.
        add_ray(ONE / 2, ONE / 2, ONE, 0, 0, -ONE, 0, 2 * ONE);
        add_ray(ONE / 2, ONE / 2, -ONE, 0, 0, ONE, 0, 2 * ONE);
        add_ray(0, 0, ONE, 0, 0, -ONE, 0, 2 * ONE);
        add_ray(ONE, ONE, ONE, 0, 0, -ONE, 0, 2 * ONE);
        add_ray(ONE + 1, ONE / 2, ONE, 0, 0, -ONE, 0, 2 * ONE);
        add_ray(ONE / 2, -1, ONE, 0, 0, -ONE, 0, 2 * ONE);
        add_ray(ONE / 2, ONE / 2, ONE, ONE, ONE, 0, 0, 2 * ONE);
        add_ray(ONE / 2, ONE / 2, ONE, 0, 0, -ONE, 0, ONE - 1);
        add_ray(ONE / 2, ONE / 2, ONE, 0, 0, -ONE, ONE + 1, 2 * ONE);
        add_ray(ONE / 2, ONE / 2, ONE, 0, 0, -ONE, ONE, ONE);
        add_ray(0, 0, ONE, ONE / 2, ONE / 2, -ONE, 0, 2 * ONE);
        add_ray(ONE / 2, ONE / 2, 64'sh7fff_ffff, 0, 0, -1, -64'sh8000_0000,
                64'sh7fff_ffff);
        add_ray(ONE / 2, ONE / 2, -64'sh8000_0000, 0, 0, 64'sh7fff_ffff,
                -64'sh8000_0000, 64'sh7fff_ffff);
        add_ray(64'sh7fff_ffff, 64'sh7fff_ffff, 64'sh7fff_ffff, 64'sh7fff_ffff,
                64'sh7fff_ffff, 64'sh7fff_ffff, 64'sh7fff_ffff, 64'sh7fff_ffff);
        add_ray(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000,
                -64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000);
        add_ray(ONE / 2, ONE / 2, ONE, 0, 0, -ONE, 2 * ONE, 0);
        wait_drained();

        // Zero width on the first axis, and second bounds reversed.
        set_rect(rai_pkg::AXIS_Z, 0, ONE, ONE, 0, ONE, 16'hffff);
        add_ray(ONE, ONE / 2, ONE, 0, 0, -ONE, 0, 2 * ONE);
        wait_drained();
        set_rect(rai_pkg::AXIS_Y, ONE, 0, ONE, ONE, 0, 16'h1234);
        add_ray(ONE / 2, 0, ONE / 2, 0, ONE, 0, 0, 2 * ONE);
        wait_drained();
        // Unused axis code: every ray misses.
        set_rect(2'd3, 0, 0, ONE, 0, ONE, 16'h00aa);
        add_ray(ONE / 2, ONE / 2, ONE, ONE, ONE, -ONE, -ONE, 4 * ONE);
        add_ray(ONE / 2, ONE / 2, ONE, 0, 0, -ONE, 0, 2 * ONE);
        wait_drained();
        // Whole coordinate range as the rectangle, plane at the extremes.
        set_rect(rai_pkg::AXIS_X, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                 32'h8000_0000, 32'h7fff_ffff, 16'hffff);
        add_ray(0, 0, 0, ONE, 0, 0, -64'sh8000_0000, 64'sh7fff_ffff);
        add_ray(-64'sh8000_0000, 5, -7, 64'sh7fff_ffff, 1, -1, 0, 64'sh7fff_ffff);
        add_random_rays(20);
        set_rect(rai_pkg::AXIS_Y, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                 32'h8000_0000, 32'h7fff_ffff, 0);
        add_ray(0, 0, 0, 3, -ONE, 2, -64'sh8000_0000, 64'sh7fff_ffff);
        add_random_rays(20);

        // Receiver idles often at first and also holds off for a long stretch.
        in_idle_pct = 26; out_idle_pct = 71;
        hold_cnt = 600;
        random_rect(rai_pkg::AXIS_Z, 120);
        random_rect(rai_pkg::AXIS_Y, 120);
        random_rect(rai_pkg::AXIS_X, 120);
        random_rect(2'd3, 40);
        in_idle_pct = 71; out_idle_pct = 26;
        random_rect(rai_pkg::AXIS_Z, 120);
        random_rect(rai_pkg::AXIS_Y, 120);
        random_rect(rai_pkg::AXIS_X, 120);
        in_idle_pct = 0; out_idle_pct = 0;
        hold_cnt = 300;
        random_rect(rai_pkg::AXIS_Z, 160);
        random_rect(rai_pkg::AXIS_Y, 160);
        random_rect(rai_pkg::AXIS_X, 160);
        set_rect(rai_pkg::AXIS_Z, 0, 0, ONE, 0, ONE, 0);
        add_random_rays(100);

        if (fail_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
